// File: rtl/rcpt_pkg.sv
// ----------------------------------------------------------------------------
// rcpt_pkg
// Shared types and constants for the rc pulse throttle/brake controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcpt_pkg;

  localparam int CHANNELS = 4;

  // channel positions on the pin bus
  localparam int CH_MODE     = 0;
  localparam int CH_FORWARD  = 1;
  localparam int CH_STEER    = 2;
  localparam int CH_THROTTLE = 3;

  // configuration register indexes
  localparam logic [1:0] REG_DRIVE_ENABLE   = 2'd0;
  localparam logic [1:0] REG_FAST_MODE      = 2'd1;
  localparam logic [1:0] REG_SIGNAL_TIMEOUT = 2'd2;

  localparam logic [19:0] TIMEOUT_RESET = 20'd50000;

  // request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // drive state codes
  localparam logic [1:0] DS_THRUST   = 2'd0;
  localparam logic [1:0] DS_BRAKING  = 2'd1;
  localparam logic [1:0] DS_PAUSED   = 2'd2;
  localparam logic [1:0] DS_DISABLED = 2'd3;

  // tick queue depth
  localparam int TQ_DEPTH = 4;
  localparam int TQ_AW    = $clog2(TQ_DEPTH);

  typedef struct packed {
    logic        drive_enable;
    logic        fast_mode;
    logic [19:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic enable;
  } brk_ld_t;

  // snapshot of the channel widths and the lost flag taken when a tick is accepted
  typedef struct packed {
    logic [15:0] thr_w;
    logic [15:0] mode_w;
    logic [15:0] steer_w;
    logic [15:0] fwd_w;
    logic        lost;
  } tick_t;

  typedef struct packed {
    logic [11:0] front_drive;
    logic [11:0] rear_drive;
    logic        brake_one;
    logic        brake_two;
    logic        reverse_line;
    logic [1:0]  drive_state;
    logic [7:0]  throttle_level;
    logic [1:0]  steering_state;
    logic [1:0]  speed_mode;
    logic        signal_lost;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/rc_pulse_throttle_brake_control.sv
// ----------------------------------------------------------------------------
// rc_pulse_throttle_brake_control
// RC pulse decoder with throttle smoothing and thrust/brake/pause control.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  in        in_push / in_full  in_req_type, in_time_us, in_pin_levels
//  out       out_pop / out_empty  drive, brake, state, steering, mode, lost
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  pin samples are taken one per cycle while in_full is low, giving no result
//  a tick is snapshotted into a 4-entry queue and then passes through the
//  back end steps (sum, reciprocal multiply, correction, decision); the back
//  end takes no new tick until the last one has left the decision step
//  in_full rises only when the tick queue is full; results wait in a 2-entry
//  output queue; a stalled consumer holds the back end, then the tick queue
//  synchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rc_pulse_throttle_brake_control (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_req_type,
  input  logic [31:0] in_time_us,
  input  logic [3:0]  in_pin_levels,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [11:0] out_front_drive,
  output logic [11:0] out_rear_drive,
  output logic        out_brake_one,
  output logic        out_brake_two,
  output logic        out_reverse_line,
  output logic [1:0]  out_drive_state,
  output logic [7:0]  out_throttle_level,
  output logic [1:0]  out_steering_state,
  output logic [1:0]  out_speed_mode,
  output logic        out_signal_lost,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import rcpt_pkg::*;

  cfg_t    cfg_r;
  brk_ld_t brk_ld;
  logic    acc;
  logic    cfg_wr;
  logic    tq_push, tq_full, tq_pop, tq_empty;
  tick_t   tq_wdata, tq_head;
  res_t    res;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign acc       = in_push && !in_full;
  assign in_full   = tq_full;

  assign brk_ld.load   = cfg_wr && cfg_index == REG_DRIVE_ENABLE;
  assign brk_ld.enable = cfg_data[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drive_enable <= 1'b0;
      cfg_r.fast_mode    <= 1'b0;
      cfg_r.timeout      <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_DRIVE_ENABLE:   cfg_r.drive_enable <= cfg_data[0];
        REG_FAST_MODE:      cfg_r.fast_mode    <= cfg_data[0];
        REG_SIGNAL_TIMEOUT: cfg_r.timeout      <= cfg_data;
        default: ;
      endcase
    end
  end

  rcpt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .req_type   (in_req_type),
    .time_us    (in_time_us),
    .pin_levels (in_pin_levels),
    .timeout    (cfg_r.timeout),
    .tq_push    (tq_push),
    .tq_data    (tq_wdata)
  );

  rcpt_tickq u_tickq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (tq_push),
    .wdata (tq_wdata),
    .full  (tq_full),
    .pop   (tq_pop),
    .rdata (tq_head),
    .empty (tq_empty)
  );

  rcpt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .brk_ld    (brk_ld),
    .tq_head   (tq_head),
    .tq_empty  (tq_empty),
    .tq_pop    (tq_pop),
    .res       (res),
    .res_empty (out_empty),
    .res_pop   (out_pop)
  );

  assign out_front_drive    = res.front_drive;
  assign out_rear_drive     = res.rear_drive;
  assign out_brake_one      = res.brake_one;
  assign out_brake_two      = res.brake_two;
  assign out_reverse_line   = res.reverse_line;
  assign out_drive_state    = res.drive_state;
  assign out_throttle_level = res.throttle_level;
  assign out_steering_state = res.steering_state;
  assign out_speed_mode     = res.speed_mode;
  assign out_signal_lost    = res.signal_lost;

endmodule

`default_nettype wire

// File: rtl/rcpt_front.sv
// ----------------------------------------------------------------------------
// rcpt_front
// Pulse edge capture for the four channels; snapshots the state for ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcpt_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic                 req_type,
  input  logic [31:0]          time_us,
  input  logic [3:0]           pin_levels,
  input  logic [19:0]          timeout,
  output logic                 tq_push,
  output rcpt_pkg::tick_t      tq_data
);
  import rcpt_pkg::*;

  logic [CHANNELS-1:0] lvl_r, lvl_nxt;
  logic [31:0]         rise_r [CHANNELS];
  logic [31:0]         rise_nxt [CHANNELS];
  logic [15:0]         wid_r [CHANNELS];
  logic [15:0]         wid_nxt [CHANNELS];
  logic [31:0]         diff [CHANNELS];
  logic [CHANNELS-1:0] late;

  always_comb begin
    lvl_nxt = lvl_r;
    for (int c = 0; c < CHANNELS; c++) begin
      rise_nxt[c] = rise_r[c];
      wid_nxt[c]  = wid_r[c];
      diff[c]     = time_us - rise_r[c];
      late[c]     = diff[c] > {12'd0, timeout};
      if (acc && req_type == REQ_SAMPLE) begin
        if (pin_levels[c] && !lvl_r[c]) begin
          lvl_nxt[c]  = 1'b1;
          rise_nxt[c] = time_us;
        end else if (!pin_levels[c] && lvl_r[c]) begin
          lvl_nxt[c] = 1'b0;
          // saturate the width at 16 bits
          wid_nxt[c] = (|diff[c][31:16]) ? 16'hFFFF : diff[c][15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        rise_r[c] <= '0;
        wid_r[c]  <= '0;
      end
    end else begin
      lvl_r <= lvl_nxt;
      for (int c = 0; c < CHANNELS; c++) begin
        rise_r[c] <= rise_nxt[c];
        wid_r[c]  <= wid_nxt[c];
      end
    end
  end

  assign tq_push         = acc && req_type == REQ_TICK;
  assign tq_data.thr_w   = wid_r[CH_THROTTLE];
  assign tq_data.mode_w  = wid_r[CH_MODE];
  assign tq_data.steer_w = wid_r[CH_STEER];
  assign tq_data.fwd_w   = wid_r[CH_FORWARD];
  assign tq_data.lost    = |late;

endmodule

`default_nettype wire

// File: rtl/rcpt_tickq.sv
// ----------------------------------------------------------------------------
// rcpt_tickq
// Small queue of tick snapshots between the capture front and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcpt_tickq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rcpt_pkg::tick_t wdata,
  output logic            full,
  input  logic            pop,
  output rcpt_pkg::tick_t rdata,
  output logic            empty
);
  import rcpt_pkg::*;

  tick_t             mem_r [TQ_DEPTH];
  logic [TQ_AW-1:0]  wp_r, wp_nxt;
  logic [TQ_AW-1:0]  rp_r, rp_nxt;
  logic [TQ_AW:0]    cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = cnt_r == (TQ_AW+1)'(TQ_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rcpt_back.sv
// ----------------------------------------------------------------------------
// rcpt_back
// Tick processing: throttle smoothing, thrust/brake/pause decision, outputs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcpt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rcpt_pkg::cfg_t    cfg,
  input  rcpt_pkg::brk_ld_t brk_ld,
  input  rcpt_pkg::tick_t   tq_head,
  input  logic              tq_empty,
  output logic              tq_pop,
  output rcpt_pkg::res_t    res,
  output logic              res_empty,
  input  logic              res_pop
);
  import rcpt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]  st_r, st_nxt;
  logic [15:0] avg_r, avg_nxt;
  logic        fwd_r, fwd_nxt;
  logic        brk1_r, brk1_nxt;
  logic        brk2_r, brk2_nxt;

  // datapath registers
  logic [19:0] s_r;
  logic [18:0] my_r;
  logic [7:0]  lvl_r;
  logic        thr_gt_r;
  logic        d_big_r;
  logic [36:0] pa_r;
  logic [29:0] pd_r;
  logic [11:0] drv_r;

  // output queue
  res_t        oq_r [2];
  logic        oq_wp_r, oq_rp_r;
  logic [1:0]  oq_cnt_r;
  logic        oq_full, oq_push, oq_pop;
  res_t        res_new;

  // front of the math
  logic [15:0] d;
  logic [8:0]  d9;
  logic [19:0] s_c;
  logic [18:0] my_c;
  logic [12:0] lvl_c;

  assign d     = tq_head.thr_w - 16'd1520;
  assign d9    = d[8:0];
  assign s_c   = {1'b0, avg_r, 3'b000} + {4'd0, avg_r} + {4'd0, tq_head.thr_w};
  assign my_c  = 19'(d9) * 19'd619;
  assign lvl_c = 13'(d9) * 13'd17;

  // divide by 10 as (s/2)/5 with a reciprocal and one correction
  logic [18:0] s_half;
  logic [16:0] qa0;
  logic [18:0] ra;
  logic [16:0] qa;
  assign s_half = s_r[19:1];
  assign qa0    = pa_r[36:20];
  assign ra     = s_half - (19'(qa0) * 19'd5);
  assign qa     = (ra >= 19'd5) ? qa0 + 17'd1 : qa0;

  // drive scaling: (d*619/32)/3 with a reciprocal and one correction
  logic [13:0] y;
  logic [13:0] qd0;
  logic [13:0] rd;
  logic [13:0] qd;
  assign y   = my_r[18:5];
  assign qd0 = pd_r[29:16];
  assign rd  = y - (qd0 * 14'd3);
  assign qd  = (rd >= 14'd3) ? qd0 + 14'd1 : qd0;

  assign oq_full = oq_cnt_r == 2'd2;
  assign oq_push = st_r == ST_OUT && !oq_full;
  assign oq_pop  = res_pop && !res_empty;
  assign tq_pop  = oq_push;

  always_comb begin
    st_nxt   = st_r;
    avg_nxt  = avg_r;
    fwd_nxt  = fwd_r;
    brk1_nxt = brk1_r;
    brk2_nxt = brk2_r;
    res_new  = '0;
    res_new.reverse_line = fwd_r;

    unique case (st_r)
      ST_IDLE: begin
        if (!tq_empty) begin
          st_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        st_nxt = ST_FIX;
      end
      ST_FIX: begin
        st_nxt = ST_OUT;
        if (cfg.drive_enable) begin
          avg_nxt = qa[15:0];
        end
      end
      ST_OUT: begin
        if (!oq_full) begin
          st_nxt = ST_IDLE;
        end
        if (!cfg.drive_enable) begin
          res_new.drive_state = DS_DISABLED;
          res_new.brake_one   = 1'b1;
          res_new.brake_two   = 1'b1;
        end else begin
          if (!cfg.fast_mode) begin
            res_new.speed_mode = 2'd2;
          end else if (tq_head.mode_w > 16'd1750) begin
            res_new.speed_mode = 2'd2;
          end else if (tq_head.mode_w > 16'd1250) begin
            res_new.speed_mode = 2'd1;
          end else begin
            res_new.speed_mode = 2'd0;
          end
          if (tq_head.steer_w > 16'd1540) begin
            res_new.steering_state = 2'd1;
          end else if (tq_head.steer_w < 16'd1460) begin
            res_new.steering_state = 2'd2;
          end
          res_new.signal_lost = tq_head.lost;

          priority if (avg_r > 16'd1520) begin
            res_new.drive_state = DS_THRUST;
            if (!thr_gt_r) begin
              res_new.front_drive = 12'd1000;
            end else if (d_big_r) begin
              res_new.front_drive    = 12'd4095;
              res_new.throttle_level = 8'd255;
            end else begin
              res_new.front_drive    = drv_r;
              res_new.throttle_level = lvl_r;
            end
            res_new.rear_drive = fwd_r ? res_new.front_drive : 12'd0;
          end else if (avg_r < 16'd1400) begin
            res_new.drive_state = DS_BRAKING;
            if (!oq_full) begin
              brk1_nxt = 1'b1;
              brk2_nxt = avg_r < 16'd1050;
            end
          end else begin
            res_new.drive_state = DS_PAUSED;
            if (!oq_full) begin
              brk1_nxt = 1'b0;
              brk2_nxt = 1'b0;
              fwd_nxt  = tq_head.fwd_w < 16'd1250;
            end
          end
          res_new.brake_one    = brk1_nxt;
          res_new.brake_two    = brk2_nxt;
          res_new.reverse_line = fwd_nxt;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase

    if (brk_ld.load) begin
      brk1_nxt = !brk_ld.enable;
      brk2_nxt = !brk_ld.enable;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      avg_r    <= 16'd1500;
      fwd_r    <= 1'b1;
      brk1_r   <= 1'b1;
      brk2_r   <= 1'b1;
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      st_r    <= st_nxt;
      avg_r   <= avg_nxt;
      fwd_r   <= fwd_nxt;
      brk1_r  <= brk1_nxt;
      brk2_r  <= brk2_nxt;
      oq_wp_r <= oq_push ? !oq_wp_r : oq_wp_r;
      oq_rp_r <= oq_pop ? !oq_rp_r : oq_rp_r;
      if (oq_push && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + 2'd1;
      end else if (oq_pop && !oq_push) begin
        oq_cnt_r <= oq_cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE) begin
      s_r      <= s_c;
      my_r     <= my_c;
      lvl_r    <= lvl_c[12:5];
      thr_gt_r <= tq_head.thr_w > 16'd1520;
      d_big_r  <= tq_head.thr_w >= 16'd2000;
    end
    if (st_r == ST_MUL) begin
      pa_r <= 37'(s_half) * 37'd209715;
      pd_r <= 30'(y) * 30'd21845;
    end
    if (st_r == ST_FIX) begin
      drv_r <= 12'd1000 + qd[11:0];
    end
    if (oq_push) begin
      oq_r[oq_wp_r] <= res_new;
    end
  end

  assign res       = oq_r[oq_rp_r];
  assign res_empty = oq_cnt_r == 2'd0;

endmodule

`default_nettype wire
